// File: hdl/frsc_pkg.sv
// package: types and constants shared by the score cache modules
package frsc_pkg;

  localparam int unsigned KeyWidth = 32;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned CapWidth = 5;
  localparam logic [CapWidth-1:0] CapReset = 5'd16;

  localparam logic OpGet = 1'b0;
  localparam logic OpPut = 1'b1;

  typedef struct packed {
    logic opcode;
    logic [KeyWidth-1:0] key;
    logic [DataWidth-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic hit;
    logic [DataWidth-1:0] read_value;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_HIT,
    ST_MISS,
    ST_EVICT_LOAD,
    ST_EVICT_DIV,
    ST_EVICT_NEXT,
    ST_INSERT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic take_request;
    logic lookup;
    logic hit_update;
    logic evict_start;
    logic evict_load;
    logic div_start;
    logic evict_compare;
    logic evict_commit;
    logic insert;
    logic result_load;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic is_put;
    logic full;
    logic div_done;
    logic scan_last;
    logic scan_valid;
  } status_t;

endpackage

// File: hdl/frequency_recency_score_cache_unit.sv
// top level: frequency over age scored key/value cache
// steps: take, lookup, then hit update or miss; a put miss inserts, after an eviction scan if full
// the eviction scan runs a serial 32-bit divide of use count by age plus one per occupied slot
// one request in flight at a time; result held in an output register
// synchronous reset empties all slots, clears the access clock, capacity to 16
module frequency_recency_score_cache_unit #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  frsc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output frsc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [frsc_pkg::CapWidth-1:0] cfg_data
);

  frsc_pkg::cmd_t cmd;
  frsc_pkg::status_t status;
  logic idle;
  logic [frsc_pkg::CapWidth-1:0] capacity;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) capacity <= frsc_pkg::CapReset;
    else if (cfg_valid && cfg_ready) capacity <= cfg_data;
  end

  frsc_controller u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_stall(out_stall), .out_valid(out_valid),
    .status(status), .cmd(cmd), .idle(idle)
  );

  frsc_datapath #(.ENTRIES(ENTRIES)) u_dp (
    .clk(clk), .rst(rst), .in_item(in_data), .capacity(capacity),
    .cmd(cmd), .status(status), .out_item(out_data)
  );

  a_take_when_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |-> idle)
    else $error("request accepted while busy");

endmodule

// File: hdl/frsc_divider.sv
// serial restoring divider: 32-bit dividend over 33-bit divisor, one bit per cycle
module frsc_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic [32:0] rem;
  logic [31:0] quo;
  logic [32:0] dsr;
  logic [5:0]  count;
  logic        busy;
  logic [33:0] shifted;
  logic [33:0] trial;

  always_comb begin
    shifted = {rem, quo[31]};
    trial = shifted - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 6'd0;
      end else if (busy) begin
        count <= count + 6'd1;
        if (count == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      if (!trial[33]) begin
        rem <= trial[32:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= shifted[32:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

endmodule

// File: hdl/frsc_controller.sv
// controller: sequencing of lookup, hit update, eviction scan and insert
module frsc_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                out_stall,
  output logic                out_valid,
  input  frsc_pkg::status_t   status,
  output frsc_pkg::cmd_t      cmd,
  output logic                idle
);

  frsc_pkg::state_t state, state_next;
  logic out_full, out_full_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= frsc_pkg::ST_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      out_full <= out_full_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_full_next = out_full;
    if (out_full && !out_stall) out_full_next = 1'b0;
    unique case (state)
      frsc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take_request = 1'b1;
          state_next = frsc_pkg::ST_LOOKUP;
        end
      end
      frsc_pkg::ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        if (status.found) state_next = frsc_pkg::ST_HIT;
        else state_next = frsc_pkg::ST_MISS;
      end
      frsc_pkg::ST_HIT: begin
        cmd.hit_update = 1'b1;
        state_next = frsc_pkg::ST_RESULT;
      end
      frsc_pkg::ST_MISS: begin
        if (!status.is_put) begin
          state_next = frsc_pkg::ST_RESULT;
        end else if (status.full) begin
          cmd.evict_start = 1'b1;
          state_next = frsc_pkg::ST_EVICT_LOAD;
        end else begin
          state_next = frsc_pkg::ST_INSERT;
        end
      end
      frsc_pkg::ST_EVICT_LOAD: begin
        cmd.evict_load = 1'b1;
        if (status.scan_valid) begin
          cmd.div_start = 1'b1;
          state_next = frsc_pkg::ST_EVICT_DIV;
        end else begin
          state_next = frsc_pkg::ST_EVICT_NEXT;
        end
      end
      frsc_pkg::ST_EVICT_DIV: begin
        if (status.div_done) begin
          cmd.evict_compare = 1'b1;
          state_next = frsc_pkg::ST_EVICT_NEXT;
        end
      end
      frsc_pkg::ST_EVICT_NEXT: begin
        if (status.scan_last) begin
          cmd.evict_commit = 1'b1;
          state_next = frsc_pkg::ST_INSERT;
        end else begin
          state_next = frsc_pkg::ST_EVICT_LOAD;
        end
      end
      frsc_pkg::ST_INSERT: begin
        cmd.insert = 1'b1;
        state_next = frsc_pkg::ST_RESULT;
      end
      frsc_pkg::ST_RESULT: begin
        if (!out_full_next) begin
          cmd.result_load = 1'b1;
          out_full_next = 1'b1;
          state_next = frsc_pkg::ST_IDLE;
        end
      end
      default: state_next = frsc_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = out_full;
  assign idle = (state == frsc_pkg::ST_IDLE);

  a_result_only_from_result_state: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |-> $past(state) != frsc_pkg::ST_IDLE || state == frsc_pkg::ST_RESULT)
    else $error("result loaded outside result state");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_full && out_stall |=> out_full)
    else $error("result dropped while stalled");
  a_accept_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.take_request |-> state == frsc_pkg::ST_IDLE)
    else $error("request taken while busy");

endmodule

// File: hdl/frsc_datapath.sv
// datapath: slot arrays, access clock, lookup, score divider and victim tracking
module frsc_datapath #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  frsc_pkg::in_item_t          in_item,
  input  logic [frsc_pkg::CapWidth-1:0] capacity,
  input  frsc_pkg::cmd_t              cmd,
  output frsc_pkg::status_t           status,
  output frsc_pkg::out_item_t         out_item
);

  localparam int unsigned IdxWidth = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntWidth = $clog2(ENTRIES + 1);

  logic [ENTRIES-1:0] slot_valid;
  logic [31:0] slot_key [ENTRIES];
  logic [31:0] slot_value [ENTRIES];
  logic [31:0] use_count [ENTRIES];
  logic [31:0] last_use_time [ENTRIES];
  logic [31:0] access_clock;

  frsc_pkg::in_item_t req;
  logic [IdxWidth-1:0] found_idx;
  logic full;
  logic hit_reg;
  logic [31:0] read_reg;

  logic [IdxWidth-1:0] scan_idx;
  logic [IdxWidth-1:0] victim;
  logic victim_set;
  logic [31:0] best;
  logic [31:0] div_num;
  logic [32:0] div_den;
  logic div_done;
  logic [31:0] quotient;

  logic match_any;
  logic [IdxWidth-1:0] match_idx;
  logic [CntWidth-1:0] occupied;
  logic [CntWidth-1:0] eff_cap;
  logic [IdxWidth-1:0] free_idx;
  logic [31:0] age;

  logic step_scan;
  logic [IdxWidth-1:0] ins_idx;
  logic in_next;

  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    occupied = '0;
    for (int s = ENTRIES - 1; s >= 0; s--) begin
      if (slot_valid[s] && slot_key[s] == req.key) begin
        match_any = 1'b1;
        match_idx = IdxWidth'(s);
      end
    end
    for (int s = 0; s < ENTRIES; s++) begin
      occupied = occupied + CntWidth'(slot_valid[s]);
    end
    free_idx = '0;
    for (int s = ENTRIES - 1; s >= 0; s--) begin
      if (!slot_valid[s]) free_idx = IdxWidth'(s);
    end
    if (capacity == '0) eff_cap = CntWidth'(1);
    else if (32'(capacity) > 32'(ENTRIES)) eff_cap = CntWidth'(ENTRIES);
    else eff_cap = CntWidth'(capacity);
    age = access_clock - last_use_time[scan_idx];
  end

  frsc_divider u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .dividend(div_num), .divisor(div_den),
    .done(div_done), .quotient(quotient)
  );

  assign div_num = use_count[scan_idx];
  assign div_den = {1'b0, age} + 33'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      access_clock <= '0;
      victim_set <= 1'b0;
      scan_idx <= '0;
    end else begin
      if (cmd.take_request) access_clock <= access_clock + 32'd1;
      if (cmd.evict_start) begin
        scan_idx <= '0;
        victim_set <= 1'b0;
      end
      if (cmd.evict_compare) begin
        if (!victim_set || quotient < best) begin
          best <= quotient;
          victim <= scan_idx;
          victim_set <= 1'b1;
        end
      end
      if (step_scan) scan_idx <= scan_idx + IdxWidth'(1);
      if (cmd.evict_commit && victim_set) slot_valid[victim] <= 1'b0;
      if (cmd.insert) slot_valid[ins_idx] <= 1'b1;
    end
  end

  // scan pointer advances when leaving the next-state step without commit
  always_ff @(posedge clk) begin
    if (rst) in_next <= 1'b0;
    else in_next <= (cmd.evict_load && !status.scan_valid) || cmd.evict_compare;
  end
  assign step_scan = in_next && !status.scan_last;

  // the victim frees its slot; lowest free slot after eviction
  always_comb begin
    ins_idx = free_idx;
    if (full && victim_set && victim < free_idx) ins_idx = victim;
    if (full && victim_set && occupied == CntWidth'(ENTRIES)) ins_idx = victim;
  end

  always_ff @(posedge clk) begin
    if (cmd.take_request) req <= in_item;
    if (cmd.lookup) begin
      found_idx <= match_idx;
      full <= occupied >= eff_cap;
      hit_reg <= match_any;
      read_reg <= '0;
    end
    if (cmd.hit_update) begin
      use_count[found_idx] <= use_count[found_idx] + 32'd1;
      last_use_time[found_idx] <= access_clock;
      if (req.opcode == frsc_pkg::OpPut) slot_value[found_idx] <= req.value;
      else read_reg <= slot_value[found_idx];
    end
    if (cmd.insert) begin
      slot_key[ins_idx] <= req.key;
      slot_value[ins_idx] <= req.value;
      use_count[ins_idx] <= 32'd1;
      last_use_time[ins_idx] <= access_clock;
    end
    if (cmd.result_load) begin
      out_item.hit <= hit_reg;
      out_item.read_value <= read_reg;
    end
  end

  always_comb begin
    status.found = match_any;
    status.is_put = (req.opcode == frsc_pkg::OpPut);
    status.full = full;
    status.div_done = div_done;
    status.scan_last = (32'(scan_idx) == 32'(ENTRIES - 1));
    status.scan_valid = slot_valid[scan_idx];
  end

  a_insert_free: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> !slot_valid[ins_idx] || (victim_set && ins_idx == victim))
    else $error("insert into occupied slot");
  a_clock_step: assert property (@(posedge clk) disable iff (rst)
    cmd.take_request |=> access_clock == $past(access_clock) + 32'd1)
    else $error("access clock did not advance");
  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.hit_update |-> slot_valid[found_idx])
    else $error("hit on invalid slot");

endmodule

// File: sim/tb_frequency_recency_score_cache_unit.sv
// testbench: score cache unit checked against a cycle-free predictor with random handshakes
`timescale 1ns / 100ps

class cache_scoreboard;
  bit slot_valid_q[16];
  logic [31:0] slot_key_q[16];
  logic [31:0] slot_value_q[16];
  logic [31:0] use_count_q[16];
  logic [31:0] last_use_q[16];
  logic [31:0] access_clock_q;
  logic [4:0] capacity_q;
  frsc_pkg::out_item_t pending_results[$];
  int mismatches;
  int checked;
  int hits;
  int evictions;

  function new();
    for (int s = 0; s < 16; s++) begin
      slot_valid_q[s] = 0;
    end
    access_clock_q = 0;
    capacity_q = frsc_pkg::CapReset;
    mismatches = 0;
    checked = 0;
    hits = 0;
    evictions = 0;
  endfunction

  function void set_capacity(logic [4:0] c);
    capacity_q = c;
  endfunction

  function void note_request(frsc_pkg::in_item_t req);
    frsc_pkg::out_item_t res;
    int found;
    int occupied;
    int victim;
    int eff_cap;
    logic [32:0] div;
    logic [32:0] sc;
    logic [32:0] best;
    found = -1;
    occupied = 0;
    victim = -1;
    best = 0;
    access_clock_q = access_clock_q + 1;
    res.hit = 0;
    res.read_value = '0;
    for (int s = 0; s < 16; s++) begin
      if (slot_valid_q[s]) begin
        occupied++;
        if (found < 0 && slot_key_q[s] == req.key) found = s;
      end
    end
    if (found >= 0) begin
      res.hit = 1;
      hits++;
      use_count_q[found] = use_count_q[found] + 1;
      last_use_q[found] = access_clock_q;
      if (req.opcode == frsc_pkg::OpPut) slot_value_q[found] = req.value;
      else res.read_value = slot_value_q[found];
    end else if (req.opcode == frsc_pkg::OpPut) begin
      eff_cap = (capacity_q < 1) ? 1 : ((capacity_q > 16) ? 16 : capacity_q);
      if (occupied >= eff_cap) begin
        for (int s = 0; s < 16; s++) begin
          if (slot_valid_q[s]) begin
            div = {1'b0, access_clock_q - last_use_q[s]} + 33'd1;
            sc = {1'b0, use_count_q[s]} / div;
            if (victim < 0 || sc < best) begin
              best = sc;
              victim = s;
            end
          end
        end
        if (victim >= 0) begin
          slot_valid_q[victim] = 0;
          evictions++;
        end
      end
      for (int s = 0; s < 16; s++) begin
        if (!slot_valid_q[s]) begin
          slot_valid_q[s] = 1;
          slot_key_q[s] = req.key;
          slot_value_q[s] = req.value;
          use_count_q[s] = 1;
          last_use_q[s] = access_clock_q;
          break;
        end
      end
    end
    pending_results.push_back(res);
  endfunction

  function void check_result(frsc_pkg::out_item_t got);
    frsc_pkg::out_item_t want;
    checked++;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result hit=%0b value=%h", got.hit, got.read_value);
      return;
    end
    want = pending_results.pop_front();
    if (got.hit !== want.hit || got.read_value !== want.read_value) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: expected hit=%0b value=%h, got hit=%0b value=%h",
                 checked, want.hit, want.read_value, got.hit, got.read_value);
    end
  endfunction
endclass

module tb_frequency_recency_score_cache_unit;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  frsc_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  frsc_pkg::out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [frsc_pkg::CapWidth-1:0] cfg_data;

  cache_scoreboard sb;
  logic [31:0] key_pool[8];
  int idle_pct;
  int quiet_cycles;
  int accepted;

  frequency_recency_score_cache_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // result side: stall at random, check on accept
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if (out_valid && !out_stall) begin
      sb.check_result(out_data);
      quiet_cycles <= 0;
    end else if (in_valid && !in_stall) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk) begin
    if (quiet_cycles > 20000) begin
      $display("timeout");
      $display("frequency_recency_score_cache_unit: mismatch");
      $finish;
    end
  end

  task automatic send_request(logic op, logic [31:0] k, logic [31:0] v);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data <= '{opcode: op, key: k, value: v};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request('{opcode: op, key: k, value: v});
    accepted++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (700) @(negedge clk);
  endtask

  task automatic write_capacity(logic [4:0] c);
    drain();
    cfg_valid <= 1;
    cfg_data <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_capacity(c);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic random_phase(int n);
    logic [31:0] k;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) drain();
      if ($urandom_range(9) < 8) k = key_pool[3'($urandom_range(7))];
      else k = $urandom;
      send_request(1'($urandom_range(1)), k, $urandom);
    end
  endtask

  initial begin
    sb = new();
    rst = 1;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    cfg_valid = 0;
    cfg_data = '0;
    idle_pct = 0;
    accepted = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'hFFFF_FFFF;
    key_pool[1] = 32'h8000_0000;
    key_pool[2] = 32'h7FFF_FFFF;
    key_pool[3] = 32'h0;

    // directed: extremes, get miss/hit, put update, evictions at capacity 1 and 0
    send_request(frsc_pkg::OpGet, 32'hFFFF_FFFF, 32'h1234);
    send_request(frsc_pkg::OpPut, 32'hFFFF_FFFF, 32'h8000_0000);
    send_request(frsc_pkg::OpGet, 32'hFFFF_FFFF, 32'h0);
    send_request(frsc_pkg::OpPut, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_request(frsc_pkg::OpGet, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(frsc_pkg::OpPut, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(frsc_pkg::OpPut, 32'h7FFF_FFFF, 32'h0);
    send_request(frsc_pkg::OpPut, 32'h0, 32'hAAAA_5555);
    send_request(frsc_pkg::OpGet, 32'h0, 32'h0);
    write_capacity(5'd1);
    send_request(frsc_pkg::OpPut, 32'h1, 32'h11);
    send_request(frsc_pkg::OpPut, 32'h2, 32'h22);
    send_request(frsc_pkg::OpGet, 32'h1, 32'h0);
    send_request(frsc_pkg::OpGet, 32'h2, 32'h0);
    write_capacity(5'd0);
    send_request(frsc_pkg::OpPut, 32'h3, 32'h33);
    send_request(frsc_pkg::OpGet, 32'h3, 32'h0);
    write_capacity(5'd31);
    for (int i = 0; i < 6; i++) send_request(frsc_pkg::OpPut, 32'h100 + i, i);

    idle_pct = 26;
    random_phase(250);
    write_capacity(5'd4);
    random_phase(250);
    idle_pct = 0;
    write_capacity(5'd16);
    random_phase(150);
    idle_pct = 26;
    write_capacity(5'd2);
    random_phase(150);
    write_capacity(5'd17);
    random_phase(200);

    drain();
    $display("%0d requests, %0d hits, %0d evictions, capacities 0 1 2 4 16 17 31",
             accepted, sb.hits, sb.evictions);
    if (sb.mismatches == 0) begin
      $display("frequency_recency_score_cache_unit: match");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("frequency_recency_score_cache_unit: mismatch");
    end
    $finish;
  end
endmodule

// File: files.f
hdl/frsc_pkg.sv
hdl/frsc_divider.sv
hdl/frsc_controller.sv
hdl/frsc_datapath.sv
hdl/frequency_recency_score_cache_unit.sv
sim/tb_frequency_recency_score_cache_unit.sv
